// ===== rtl/v3mu_pkg.sv =====
// Shared types, constants and a helper function of the 3-vector math unit.
`timescale 1ns / 1ps

package v3mu_pkg;

	// Component width and register widths.
	localparam int QW        = 32;
	localparam int TOL_W     = 31;
	localparam int CFG_IDX_W = 2;
	localparam int SAT_W     = 68;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_EQUAL_TOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORM_TOL  = 2'd1;

	// Configuration reset values.
	localparam logic [TOL_W-1:0] EQUAL_TOL_RST = 31'd66;
	localparam logic [TOL_W-1:0] NORM_TOL_RST  = 31'd0;

	// Saturation limits of a Q component.
	localparam logic signed [QW-1:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

	typedef logic signed [QW-1:0] q_t;

	// Operation codes.
	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_NEG   = 4'd2,
		OP_SCALE = 4'd3,
		OP_DIV   = 4'd4,
		OP_DOT   = 4'd5,
		OP_CROSS = 4'd6,
		OP_LEN   = 4'd7,
		OP_LENSQ = 4'd8,
		OP_NORM  = 4'd9,
		OP_EQUAL = 4'd10
	} opcode_t;

	// One input transaction.
	typedef struct packed {
		logic [3:0] opcode;
		q_t         a_x;
		q_t         a_y;
		q_t         a_z;
		q_t         b_x;
		q_t         b_y;
		q_t         b_z;
		q_t         scalar_in;
	} op_item_t;

	// One result transaction.
	typedef struct packed {
		q_t   res_x;
		q_t   res_y;
		q_t   res_z;
		q_t   res_scalar;
		logic is_equal;
		logic divide_by_zero;
	} rsp_item_t;

	// Per-item control and partial results that travel down the pipeline.
	typedef struct packed {
		logic [3:0]    opcode;
		q_t [2:0]      a;
		logic          den_neg;
		logic [QW-1:0] den;
		q_t [2:0]      vec;
		q_t            scal;
		logic          eq;
		logic          dz;
		logic          use_div;
	} carry_t;

	// Saturate a wide signed value to the Q range.
	function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
		q_t r;
		if (v > SAT_W'(Q_MAX)) begin
			r = Q_MAX;
		end else if (v < SAT_W'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = q_t'(v[QW-1:0]);
		end
		return r;
	endfunction

endpackage

// ===== rtl/vector3_math_unit.sv =====
// Top level of the pipelined 3-vector math unit.
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while op_stall is low; four front stages, one stage
// per root bit of the square root, one stage per quotient bit of the three divider lanes and
// a final stage set the depth. A two-entry output (result register plus skid register) lets
// the pipeline run on while a result waits. Reset clears all valid bits and loads the
// tolerance reset values.

module vector3_math_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 op_valid,
	output logic                                 op_stall,
	input  v3mu_pkg::op_item_t                   op_data,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output v3mu_pkg::rsp_item_t                  rsp_data,
	input  logic                                 cfg_we,
	input  logic [v3mu_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [v3mu_pkg::TOL_W-1:0]           cfg_wdata
);
	import v3mu_pkg::*;

	localparam int NB       = QW + FRAC_BITS;
	localparam int SQ_STEPS = QW;
	localparam int SQR_W    = QW + 3;
	localparam int PW       = 2 * (QW + 1);
	localparam int SUM_W    = PW + 1;
	localparam int VW       = 2 * QW;
	localparam int NST      = 4 + SQ_STEPS + NB + 1;
	localparam int TSQ_W    = 2 * TOL_W;
	localparam logic [VW-1:0] QMAX_U = VW'(32'h7fff_ffff);
	localparam logic [NB-1:0] QMAX_NB = NB'(32'h7fff_ffff);
	localparam logic [NB-1:0] QMIN_MAG = NB'(33'h0_8000_0000);

	// One square-root step: bring in two bits and try the next root bit.
	function automatic logic [SQR_W+QW-1:0] sqrt_step(input logic [SQR_W-1:0] rem,
			input logic [QW-1:0] root, input logic [1:0] bits);
		logic [SQR_W-1:0] acc;
		logic [SQR_W-1:0] trial;
		acc   = {rem[SQR_W-3:0], bits};
		trial = SQR_W'({root, 2'b01});
		if (acc >= trial) begin
			return {acc - trial, root[QW-2:0], 1'b1};
		end
		return {acc, root[QW-2:0], 1'b0};
	endfunction

	// One restoring division step: bring in a numerator bit, emit one quotient bit.
	function automatic logic [QW+NB-1:0] div_step(input logic [QW-1:0] rem,
			input logic [NB-1:0] nq, input logic [QW-1:0] den);
		logic [QW:0] acc;
		acc = {rem, nq[NB-1]};
		if (acc >= {1'b0, den}) begin
			return {QW'(acc - {1'b0, den}), nq[NB-2:0], 1'b1};
		end
		return {acc[QW-1:0], nq[NB-2:0], 1'b0};
	endfunction

	// Configuration registers and the squared equality tolerance.
	logic [TOL_W-1:0] tol_eq_q;
	logic [TOL_W-1:0] tol_n_q;
	logic [TSQ_W-1:0] tolsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_eq_q <= EQUAL_TOL_RST;
			tol_n_q  <= NORM_TOL_RST;
			tolsq_q  <= TSQ_W'(EQUAL_TOL_RST) * TSQ_W'(EQUAL_TOL_RST);
		end else begin
			tolsq_q <= TSQ_W'(tol_eq_q) * TSQ_W'(tol_eq_q);
			if (cfg_we) begin
				case (cfg_idx)
					CFG_EQUAL_TOL: tol_eq_q <= cfg_wdata;
					CFG_NORM_TOL:  tol_n_q  <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// Pipeline advance and valid bits.
	logic            skid_vld_q;
	logic            adv;
	logic [NST-1:0]  vld_s;

	assign adv      = !skid_vld_q;
	assign op_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], op_valid};
		end
	end

	// Stage 1: simple results, divisor magnitude and multiplier operands.
	q_t [2:0]               ia;
	q_t [2:0]               ib;
	logic signed [QW:0]     add_w [3];
	logic signed [QW:0]     dif_w [3];
	logic signed [QW:0]     neg_w [3];
	logic signed [QW:0]     ma_c [6];
	logic signed [QW:0]     mb_c [6];
	logic signed [QW:0]     s_w;
	carry_t                 ctl_c;

	always_comb begin
		ia  = {op_data.a_z, op_data.a_y, op_data.a_x};
		ib  = {op_data.b_z, op_data.b_y, op_data.b_x};
		s_w = (QW+1)'(op_data.scalar_in);
		for (int i = 0; i < 3; i++) begin
			add_w[i] = (QW+1)'(ia[i]) + (QW+1)'(ib[i]);
			dif_w[i] = (QW+1)'(ia[i]) - (QW+1)'(ib[i]);
			neg_w[i] = -(QW+1)'(ia[i]);
		end
		ctl_c         = '0;
		ctl_c.opcode  = op_data.opcode;
		ctl_c.a       = ia;
		ctl_c.den_neg = op_data.scalar_in[QW-1];
		ctl_c.den     = op_data.scalar_in[QW-1] ? QW'(-s_w) : QW'(s_w);
		for (int j = 0; j < 6; j++) begin
			ma_c[j] = '0;
			mb_c[j] = '0;
		end
		case (opcode_t'(op_data.opcode))
			OP_ADD: begin
				for (int i = 0; i < 3; i++) ctl_c.vec[i] = sat_q(SAT_W'(add_w[i]));
			end
			OP_SUB: begin
				for (int i = 0; i < 3; i++) ctl_c.vec[i] = sat_q(SAT_W'(dif_w[i]));
			end
			OP_NEG: begin
				for (int i = 0; i < 3; i++) ctl_c.vec[i] = sat_q(SAT_W'(neg_w[i]));
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					ma_c[i] = (QW+1)'(ia[i]);
					mb_c[i] = s_w;
				end
			end
			OP_DIV: begin
				if (op_data.scalar_in == '0) begin
					ctl_c.dz = 1'b1;
					for (int i = 0; i < 3; i++) begin
						if (ia[i] > 0) begin
							ctl_c.vec[i] = Q_MAX;
						end else if (ia[i] < 0) begin
							ctl_c.vec[i] = Q_MIN;
						end
					end
				end else begin
					ctl_c.use_div = 1'b1;
				end
			end
			OP_DOT: begin
				for (int i = 0; i < 3; i++) begin
					ma_c[i] = (QW+1)'(ia[i]);
					mb_c[i] = (QW+1)'(ib[i]);
				end
			end
			OP_CROSS: begin
				ma_c[0] = (QW+1)'(ia[1]); mb_c[0] = (QW+1)'(ib[2]);
				ma_c[1] = (QW+1)'(ia[2]); mb_c[1] = (QW+1)'(ib[0]);
				ma_c[2] = (QW+1)'(ia[0]); mb_c[2] = (QW+1)'(ib[1]);
				ma_c[3] = (QW+1)'(ia[2]); mb_c[3] = (QW+1)'(ib[1]);
				ma_c[4] = (QW+1)'(ia[0]); mb_c[4] = (QW+1)'(ib[2]);
				ma_c[5] = (QW+1)'(ia[1]); mb_c[5] = (QW+1)'(ib[0]);
			end
			OP_LEN, OP_LENSQ, OP_NORM: begin
				for (int i = 0; i < 3; i++) begin
					ma_c[i] = (QW+1)'(ia[i]);
					mb_c[i] = (QW+1)'(ia[i]);
				end
			end
			OP_EQUAL: begin
				for (int i = 0; i < 3; i++) begin
					ma_c[i] = dif_w[i];
					mb_c[i] = dif_w[i];
				end
			end
			default: ;
		endcase
		if (opcode_t'(op_data.opcode) != OP_DIV) begin
			ctl_c.den_neg = 1'b0;
		end
	end

	carry_t             ctl_s1;
	logic signed [QW:0] ma_s1 [6];
	logic signed [QW:0] mb_s1 [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_c;
			ma_s1  <= ma_c;
			mb_s1  <= mb_c;
		end
	end

	// Stage 2: six shared multipliers.
	carry_t                ctl_s2;
	logic signed [PW-1:0]  p_s2 [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_s1;
			for (int j = 0; j < 6; j++) p_s2[j] <= ma_s1[j] * mb_s1[j];
		end
	end

	// Stage 3: exact sums of products.
	carry_t                 ctl_s3;
	logic signed [SUM_W-1:0] sum3_s3;
	logic signed [SUM_W-1:0] crs_s3 [3];
	logic signed [PW-1:0]    scl_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3  <= ctl_s2;
			sum3_s3 <= SUM_W'(p_s2[0]) + SUM_W'(p_s2[1]) + SUM_W'(p_s2[2]);
			for (int i = 0; i < 3; i++) begin
				crs_s3[i] <= SUM_W'(p_s2[i]) - SUM_W'(p_s2[i+3]);
				scl_s3[i] <= p_s2[i];
			end
		end
	end

	// Stage 4: rescale, saturate, compare against the tolerances.
	carry_t                  ctl_c4;
	logic [VW-1:0]           sumsq_c4;
	logic [VW-1:0]           lsq_c4;
	logic signed [SUM_W-1:0] dot_sh_c4;

	always_comb begin
		ctl_c4    = ctl_s3;
		sumsq_c4  = sum3_s3[VW-1:0];
		lsq_c4    = sumsq_c4 >> FRAC_BITS;
		dot_sh_c4 = sum3_s3 >>> FRAC_BITS;
		case (opcode_t'(ctl_s3.opcode))
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					ctl_c4.vec[i] = sat_q(SAT_W'(scl_s3[i] >>> FRAC_BITS));
				end
			end
			OP_DOT: ctl_c4.scal = sat_q(SAT_W'(dot_sh_c4));
			OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					ctl_c4.vec[i] = sat_q(SAT_W'(crs_s3[i] >>> FRAC_BITS));
				end
			end
			OP_LENSQ: ctl_c4.scal = (lsq_c4 > QMAX_U) ? Q_MAX : q_t'(lsq_c4[QW-1:0]);
			OP_NORM: begin
				if ((sumsq_c4 <= (VW'(tol_n_q) << FRAC_BITS)) ||
						(sumsq_c4 == (VW'(1) << (2 * FRAC_BITS)))) begin
					ctl_c4.vec = ctl_s3.a;
				end else begin
					ctl_c4.use_div = 1'b1;
				end
			end
			OP_EQUAL: ctl_c4.eq = ($unsigned(sum3_s3) <= SUM_W'(tolsq_q));
			default: ;
		endcase
	end

	carry_t        ctl_s4;
	logic [VW-1:0] v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_c4;
			v_s4   <= sumsq_c4;
		end
	end

	// Square-root stages: one root bit per stage.
	carry_t           sq_ctl_s  [SQ_STEPS];
	logic [VW-1:0]    sq_v_s    [SQ_STEPS];
	logic [SQR_W-1:0] sq_rem_s  [SQ_STEPS];
	logic [QW-1:0]    sq_root_s [SQ_STEPS];

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		carry_t           ctl_in;
		logic [VW-1:0]    v_in;
		logic [SQR_W-1:0] rem_in;
		logic [QW-1:0]    root_in;
		if (j == 0) begin : g_first
			assign ctl_in  = ctl_s4;
			assign v_in    = v_s4;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign ctl_in  = sq_ctl_s[j-1];
			assign v_in    = sq_v_s[j-1];
			assign rem_in  = sq_rem_s[j-1];
			assign root_in = sq_root_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_ctl_s[j] <= ctl_in;
				sq_v_s[j]   <= v_in;
				{sq_rem_s[j], sq_root_s[j]} <=
					sqrt_step(rem_in, root_in, v_in[VW-1-2*j -: 2]);
			end
		end
	end

	// Divider set-up: pick the divisor and finish the length result.
	carry_t        dv_ctl_c;
	logic [NB-1:0] dv_nq_c [3];
	logic [QW-1:0] root_c;

	always_comb begin
		root_c   = sq_root_s[SQ_STEPS-1];
		dv_ctl_c = sq_ctl_s[SQ_STEPS-1];
		if (opcode_t'(dv_ctl_c.opcode) == OP_NORM) begin
			dv_ctl_c.den = root_c;
		end
		if (opcode_t'(dv_ctl_c.opcode) == OP_LEN) begin
			dv_ctl_c.scal = root_c[QW-1] ? Q_MAX : q_t'(root_c);
		end
		for (int i = 0; i < 3; i++) begin
			dv_nq_c[i] = dv_ctl_c.a[i][QW-1] ?
				{QW'(-(QW+1)'(dv_ctl_c.a[i])), FRAC_BITS'(0)} :
				{QW'(dv_ctl_c.a[i]), FRAC_BITS'(0)};
		end
	end

	// Divider stages: three lanes, one quotient bit per stage.
	carry_t        dv_ctl_s [NB];
	logic [QW-1:0] dv_rem_s [NB][3];
	logic [NB-1:0] dv_nq_s  [NB][3];

	for (genvar k = 0; k < NB; k++) begin : g_div
		carry_t        ctl_in;
		logic [QW-1:0] rem_in [3];
		logic [NB-1:0] nq_in  [3];
		if (k == 0) begin : g_first
			assign ctl_in = dv_ctl_c;
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_in[i] = '0;
				assign nq_in[i]  = dv_nq_c[i];
			end
		end else begin : g_next
			assign ctl_in = dv_ctl_s[k-1];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_in[i] = dv_rem_s[k-1][i];
				assign nq_in[i]  = dv_nq_s[k-1][i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ctl_s[k] <= ctl_in;
				for (int i = 0; i < 3; i++) begin
					{dv_rem_s[k][i], dv_nq_s[k][i]} <= div_step(rem_in[i], nq_in[i], ctl_in.den);
				end
			end
		end
	end

	// Final stage: sign and saturate the quotients, assemble the transaction.
	carry_t        fin_ctl;
	q_t [2:0]      quo_c;
	logic [NB-1:0] q_mag;
	logic          q_neg;
	rsp_item_t     fin_c;
	rsp_item_t     fin_s;

	always_comb begin
		fin_ctl = dv_ctl_s[NB-1];
		for (int i = 0; i < 3; i++) begin
			q_mag = dv_nq_s[NB-1][i];
			q_neg = fin_ctl.a[i][QW-1] ^ fin_ctl.den_neg;
			if (!q_neg) begin
				quo_c[i] = (q_mag > QMAX_NB) ? Q_MAX : q_t'(q_mag[QW-1:0]);
			end else begin
				quo_c[i] = (q_mag > QMIN_MAG) ? Q_MIN : q_t'(-q_mag[QW-1:0]);
			end
		end
		fin_c.res_x          = fin_ctl.use_div ? quo_c[0] : fin_ctl.vec[0];
		fin_c.res_y          = fin_ctl.use_div ? quo_c[1] : fin_ctl.vec[1];
		fin_c.res_z          = fin_ctl.use_div ? quo_c[2] : fin_ctl.vec[2];
		fin_c.res_scalar     = fin_ctl.scal;
		fin_c.is_equal       = fin_ctl.eq;
		fin_c.divide_by_zero = fin_ctl.dz;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_s <= fin_c;
		end
	end

	// Output register with a skid register behind it.
	logic      rsp_vld_q;
	rsp_item_t rsp_data_q;
	rsp_item_t skid_data_q;
	logic      rsp_free;

	assign rsp_free = !rsp_vld_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (rsp_free) begin
			if (skid_vld_q) begin
				rsp_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				rsp_vld_q <= vld_s[NST-1];
			end
		end else if (!skid_vld_q && vld_s[NST-1]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_free) begin
			rsp_data_q <= skid_vld_q ? skid_data_q : fin_s;
		end else if (!skid_vld_q) begin
			skid_data_q <= fin_s;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_data_q;

endmodule

// ===== rtl/v3mu_chk.sv =====
// Port-level checker of the 3-vector math unit and its bind statement.
`timescale 1ns / 1ps

module v3mu_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           rsp_valid,
	input logic                           rsp_stall,
	input v3mu_pkg::rsp_item_t            rsp_data
);
	import v3mu_pkg::*;

	// A stalled result transaction stays and holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result transaction changed while stalled");

	// Once reset has been seen at a clock edge, no result is pending.
	a_rsp_reset: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("result valid during reset");

	// A divide-by-zero result carries no scalar and no equality flag.
	a_dz_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.divide_by_zero |->
		rsp_data.res_scalar == '0 && !rsp_data.is_equal)
		else $error("divide-by-zero result has stray fields");

	// An equality result has all numeric fields cleared.
	a_eq_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.is_equal |->
		rsp_data.res_x == '0 && rsp_data.res_y == '0 && rsp_data.res_z == '0 &&
		rsp_data.res_scalar == '0 && !rsp_data.divide_by_zero)
		else $error("equality result has stray fields");

endmodule

bind vector3_math_unit v3mu_chk u_v3mu_chk (.*);
